/* rtl/tmtw_pkg.sv */
package tmtw_pkg;

  localparam int DEF_COLUMNS = 80;
  localparam int DEF_ROWS    = 25;

  localparam logic [7:0] NEWLINE_BYTE    = 8'h0A;
  localparam logic [7:0] SPACE_BYTE      = 8'h20;
  localparam logic [7:0] RESET_ATTRIBUTE = 8'h07;

  typedef enum logic [1:0] {
    OP_WRITE     = 2'd0,
    OP_BACKSPACE = 2'd1,
    OP_CLEAR     = 2'd2,
    OP_READ      = 2'd3
  } opcode_t;

  typedef struct packed {
    opcode_t     opcode;
    logic [7:0]  character;
    logic [10:0] cell_index;
  } in_word_t;

  typedef struct packed {
    logic [4:0]  cursor_row;
    logic [6:0]  cursor_column;
    logic [10:0] cursor_position;
    logic [15:0] cell_value;
  } out_word_t;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic latch_in;
    logic exec;
    logic take_value;
    logic load_out;
    logic start_clear;
    logic start_scroll;
    logic start_last;
    logic blank_step;
    logic scroll_step;
    logic fill_reset;
  } cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    opcode_t opcode;
    logic    idx_ok;
    logic    need_scroll;
    logic    sweep_last;
    logic    copy_end;
  } sts_t;

endpackage

/* rtl/text_mode_terminal_writer.sv */
// Channel   Direction  Word                  Handshake
// in_       input      tmtw_pkg::in_word_t   in_valid / in_ready
// out_      output     tmtw_pkg::out_word_t  out_valid / out_ready
// cfg_      input      8-bit attribute       cfg_valid / cfg_ready (always ready)
//
// After a word is accepted the block runs S_EXEC, then S_READ for an in-range read, S_BLANK
// for a clear, or S_SCROLL and S_BLANK for a scroll, and the result register loads in S_DONE
// once the output is free. Clear blanks the cell store one cell per cycle; a scroll copies one
// cell per cycle with a read and a write in the same cycle, then blanks the last line. After
// reset the store is filled with blank cells before in_ready rises. A new word is accepted
// while the previous result still waits on out_ready.
module text_mode_terminal_writer #(
  parameter int COLUMNS = tmtw_pkg::DEF_COLUMNS,
  parameter int ROWS    = tmtw_pkg::DEF_ROWS
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_ready,
  input  tmtw_pkg::in_word_t  in_word,
  output logic                out_valid,
  input  logic                out_ready,
  output tmtw_pkg::out_word_t out_word,
  input  logic                cfg_valid,
  output logic                cfg_ready,
  input  logic [7:0]          cfg_data
);

  tmtw_pkg::cmd_t cmd;
  tmtw_pkg::sts_t sts;

  assign cfg_ready = 1'b1;

  tmtw_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .sts       (sts),
    .cmd       (cmd)
  );

  tmtw_datapath #(
    .COLUMNS (COLUMNS),
    .ROWS    (ROWS)
  ) u_datapath (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_word  (in_word),
    .cfg_we   (cfg_valid && cfg_ready),
    .cfg_data (cfg_data),
    .cmd      (cmd),
    .sts      (sts),
    .out_word (out_word)
  );

  // The block is busy on the cycle after it takes a word.
  a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready |=> !in_ready)
    else $error("input accepted twice in consecutive cycles");

  // A new result only appears out of a busy cycle.
  a_result_from_work: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid) |-> $past(!in_ready))
    else $error("result raised without work in progress");

  // Reset starts the fill pass with no result pending.
  a_reset_fill: assert property (@(posedge clk)
    !rst_n |=> !out_valid && !in_ready)
    else $error("block not in fill pass after reset");

endmodule

/* rtl/tmtw_datapath.sv */
module tmtw_datapath #(
  parameter int COLUMNS = tmtw_pkg::DEF_COLUMNS,
  parameter int ROWS    = tmtw_pkg::DEF_ROWS
) (
  input  logic                clk,
  input  logic                rst_n,
  input  tmtw_pkg::in_word_t  in_word,
  input  logic                cfg_we,
  input  logic [7:0]          cfg_data,
  input  tmtw_pkg::cmd_t      cmd,
  output tmtw_pkg::sts_t      sts,
  output tmtw_pkg::out_word_t out_word
);

  localparam int CELLS = ROWS * COLUMNS;
  localparam int AW    = $clog2(CELLS);
  localparam int CW    = $clog2(CELLS + 1);
  localparam int RW    = $clog2(ROWS);
  localparam int COLW  = $clog2(COLUMNS);

  tmtw_pkg::in_word_t  in_r;
  tmtw_pkg::out_word_t out_r;
  logic [RW-1:0]       row_r, row_nxt;
  logic [COLW-1:0]     col_r, col_nxt;
  logic [7:0]          attr_r;
  logic [CW-1:0]       cnt_r, cnt_nxt;
  logic                pend_r;
  logic [AW-1:0]       wr_addr_r;
  logic [15:0]         value_r;
  logic [15:0]         rdata_r;
  logic [15:0]         mem [CELLS];

  logic [AW-1:0] cur_addr;
  logic [15:0]   blank;
  logic          is_nl, last_col, last_row, copy_end;
  logic          we;
  logic [AW-1:0] waddr, raddr;
  logic [15:0]   wdata;

  assign cur_addr = AW'(row_r * COLUMNS) + AW'(col_r);
  assign blank    = {attr_r, tmtw_pkg::SPACE_BYTE};
  assign is_nl    = (in_r.character == tmtw_pkg::NEWLINE_BYTE);
  assign last_col = (col_r == COLW'(COLUMNS - 1));
  assign last_row = (row_r == RW'(ROWS - 1));
  assign copy_end = (cnt_r == CW'(CELLS));

  assign sts.opcode      = in_r.opcode;
  assign sts.idx_ok      = (32'(in_r.cell_index) < 32'(CELLS));
  assign sts.need_scroll = (in_r.opcode == tmtw_pkg::OP_WRITE) && (is_nl || last_col) && last_row;
  assign sts.sweep_last  = (cnt_r == CW'(CELLS - 1));
  assign sts.copy_end    = copy_end;

  assign out_word = out_r;

  // Cursor update; a scroll leaves the row on the last line.
  always_comb begin
    row_nxt = row_r;
    col_nxt = col_r;
    if (cmd.exec) begin
      case (in_r.opcode)
        tmtw_pkg::OP_WRITE: begin
          if (is_nl || last_col) begin
            col_nxt = '0;
            if (!last_row) begin
              row_nxt = row_r + 1'b1;
            end
          end else begin
            col_nxt = col_r + 1'b1;
          end
        end
        tmtw_pkg::OP_BACKSPACE: begin
          if (col_r != '0) begin
            col_nxt = col_r - 1'b1;
          end
        end
        default: ;
      endcase
    end
  end

  always_comb begin
    we    = 1'b0;
    waddr = cnt_r[AW-1:0];
    wdata = blank;
    raddr = cnt_r[AW-1:0];
    if (cmd.exec && in_r.opcode == tmtw_pkg::OP_WRITE && !is_nl) begin
      we    = 1'b1;
      waddr = cur_addr;
      wdata = {attr_r, in_r.character};
    end else if (cmd.exec && in_r.opcode == tmtw_pkg::OP_BACKSPACE && col_r != '0) begin
      we    = 1'b1;
      waddr = cur_addr - 1'b1;
    end else if (cmd.scroll_step && pend_r) begin
      we    = 1'b1;
      waddr = wr_addr_r;
      wdata = rdata_r;
    end else if (cmd.blank_step) begin
      we = 1'b1;
      if (cmd.fill_reset) begin
        wdata = {tmtw_pkg::RESET_ATTRIBUTE, tmtw_pkg::SPACE_BYTE};
      end
    end
    if (cmd.exec && in_r.opcode == tmtw_pkg::OP_READ) begin
      raddr = AW'(in_r.cell_index);
    end
  end

  always_comb begin
    cnt_nxt = cnt_r;
    if (cmd.start_clear) begin
      cnt_nxt = '0;
    end else if (cmd.start_scroll) begin
      cnt_nxt = CW'(COLUMNS);
    end else if (cmd.start_last) begin
      cnt_nxt = CW'(CELLS - COLUMNS);
    end else if (cmd.blank_step || (cmd.scroll_step && !copy_end)) begin
      cnt_nxt = cnt_r + 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata_r <= mem[raddr];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      row_r  <= '0;
      col_r  <= '0;
      attr_r <= tmtw_pkg::RESET_ATTRIBUTE;
      cnt_r  <= '0;
      pend_r <= 1'b0;
    end else begin
      row_r <= row_nxt;
      col_r <= col_nxt;
      cnt_r <= cnt_nxt;
      if (cfg_we) begin
        attr_r <= cfg_data;
      end
      // A copy in flight writes the cell it read one line higher, while the next read goes on.
      if (cmd.start_scroll) begin
        pend_r <= 1'b0;
      end else if (cmd.scroll_step) begin
        pend_r <= !copy_end;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.latch_in) begin
      in_r <= in_word;
    end
    if (cmd.scroll_step) begin
      wr_addr_r <= AW'(cnt_r - CW'(COLUMNS));
    end
    if (cmd.exec) begin
      value_r <= '0;
    end else if (cmd.take_value) begin
      value_r <= rdata_r;
    end
    if (cmd.load_out) begin
      out_r.cursor_row      <= 5'(row_r);
      out_r.cursor_column   <= 7'(col_r);
      out_r.cursor_position <= 11'(cur_addr);
      out_r.cell_value      <= value_r;
    end
  end

endmodule

/* rtl/tmtw_ctrl.sv */
module tmtw_ctrl (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           in_valid,
  output logic           in_ready,
  output logic           out_valid,
  input  logic           out_ready,
  input  tmtw_pkg::sts_t sts,
  output tmtw_pkg::cmd_t cmd
);

  typedef enum logic [6:0] {
    S_INIT   = 7'b0000001,
    S_IDLE   = 7'b0000010,
    S_EXEC   = 7'b0000100,
    S_READ   = 7'b0001000,
    S_SCROLL = 7'b0010000,
    S_BLANK  = 7'b0100000,
    S_DONE   = 7'b1000000
  } state_t;

  state_t state_r, state_nxt;
  logic   out_valid_r, out_valid_nxt;
  logic   out_free;

  assign in_ready  = (state_r == S_IDLE);
  assign out_valid = out_valid_r;
  assign out_free  = !out_valid_r || out_ready;

  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    case (state_r)
      S_INIT: begin
        cmd.blank_step = 1'b1;
        cmd.fill_reset = 1'b1;
        if (sts.sweep_last) begin
          state_nxt = S_IDLE;
        end
      end
      S_IDLE: begin
        if (in_valid) begin
          cmd.latch_in = 1'b1;
          state_nxt    = S_EXEC;
        end
      end
      S_EXEC: begin
        cmd.exec = 1'b1;
        case (sts.opcode)
          tmtw_pkg::OP_CLEAR: begin
            cmd.start_clear = 1'b1;
            state_nxt       = S_BLANK;
          end
          tmtw_pkg::OP_READ: begin
            state_nxt = sts.idx_ok ? S_READ : S_DONE;
          end
          tmtw_pkg::OP_WRITE: begin
            if (sts.need_scroll) begin
              cmd.start_scroll = 1'b1;
              state_nxt        = S_SCROLL;
            end else begin
              state_nxt = S_DONE;
            end
          end
          default: state_nxt = S_DONE;
        endcase
      end
      S_READ: begin
        cmd.take_value = 1'b1;
        state_nxt      = S_DONE;
      end
      S_SCROLL: begin
        cmd.scroll_step = 1'b1;
        if (sts.copy_end) begin
          cmd.start_last = 1'b1;
          state_nxt      = S_BLANK;
        end
      end
      S_BLANK: begin
        cmd.blank_step = 1'b1;
        if (sts.sweep_last) begin
          state_nxt = S_DONE;
        end
      end
      S_DONE: begin
        if (out_free) begin
          cmd.load_out = 1'b1;
          state_nxt    = S_IDLE;
        end
      end
      default: state_nxt = S_INIT;
    endcase
  end

  always_comb begin
    out_valid_nxt = out_valid_r;
    if (cmd.load_out) begin
      out_valid_nxt = 1'b1;
    end else if (out_ready) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_INIT;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

endmodule

/* tb/testbench.sv */
`timescale 1ns / 1ps

module testbench;

  localparam int COLS            = tmtw_pkg::DEF_COLUMNS;
  localparam int ROWS_N          = tmtw_pkg::DEF_ROWS;
  localparam int CELLS           = COLS * ROWS_N;
  localparam int HOLD_OFF_CYCLES = 5000;
  localparam int PHASE_WORDS     = 65;

  typedef enum logic {ROW_WORD, ROW_ATTR} row_kind_t;

  typedef struct {
    row_kind_t           kind;
    tmtw_pkg::in_word_t  word;
    logic [7:0]          attr;
    bit                  typed;
    tmtw_pkg::out_word_t result;
  } stim_row_t;

  logic                clk = 1'b0;
  logic                rst_n = 1'b0;
  logic                in_valid = 1'b0;
  logic                in_ready;
  tmtw_pkg::in_word_t  in_word = '0;
  logic                out_valid;
  logic                out_ready = 1'b0;
  tmtw_pkg::out_word_t out_word;
  logic                cfg_valid = 1'b0;
  logic                cfg_ready;
  logic [7:0]          cfg_data = '0;

  // Shadow copy of the console: cell store, cursor and colour attribute.
  logic [15:0] shadow_cells [0:CELLS-1];
  int unsigned shadow_row;
  int unsigned shadow_col;
  logic [7:0]  shadow_attr;

  tmtw_pkg::out_word_t pending_results [$];

  int words_accepted  = 0;
  int results_checked = 0;
  int error_count     = 0;
  int scroll_count    = 0;
  int clear_count     = 0;
  int read_count      = 0;
  int attr_writes     = 0;
  int burst_left      = 1;
  int hold_offs_wanted = 0;
  int hold_offs_done   = 0;

  text_mode_terminal_writer u_dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_word   (in_word),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_word  (out_word),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_data  (cfg_data)
  );

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  initial begin
    #20000000;
    $display("FAILURE");
    $finish;
  end

  function automatic void line_feed();
    shadow_col = 0;
    shadow_row++;
    if (shadow_row >= ROWS_N) begin
      for (int i = 0; i < CELLS - COLS; i++) shadow_cells[i] = shadow_cells[i + COLS];
      shadow_row = ROWS_N - 1;
      for (int i = 0; i < COLS; i++)
        shadow_cells[shadow_row * COLS + i] = {shadow_attr, tmtw_pkg::SPACE_BYTE};
      scroll_count++;
    end
  endfunction

  task automatic step_console(input tmtw_pkg::in_word_t w, output tmtw_pkg::out_word_t r);
    int unsigned pos;
    logic [15:0] value;
    value = '0;
    case (w.opcode)
      tmtw_pkg::OP_WRITE: begin
        if (w.character == tmtw_pkg::NEWLINE_BYTE) begin
          line_feed();
        end else begin
          shadow_cells[shadow_row * COLS + shadow_col] = {shadow_attr, w.character};
          shadow_col++;
          if (shadow_col >= COLS) line_feed();
        end
      end
      tmtw_pkg::OP_BACKSPACE: begin
        if (shadow_col > 0) begin
          shadow_col--;
          shadow_cells[shadow_row * COLS + shadow_col] = {shadow_attr, tmtw_pkg::SPACE_BYTE};
        end
      end
      tmtw_pkg::OP_CLEAR: begin
        for (int i = 0; i < CELLS; i++) shadow_cells[i] = {shadow_attr, tmtw_pkg::SPACE_BYTE};
        clear_count++;
      end
      default: begin
        // Reads past the end of the store return zero.
        if (w.cell_index < CELLS) value = shadow_cells[w.cell_index];
        read_count++;
      end
    endcase
    pos = shadow_row * COLS + shadow_col;
    r.cursor_row      = shadow_row[4:0];
    r.cursor_column   = shadow_col[6:0];
    r.cursor_position = pos[10:0];
    r.cell_value      = value;
  endtask

  function automatic tmtw_pkg::in_word_t make_word(tmtw_pkg::opcode_t op, logic [7:0] ch,
                                                   logic [10:0] idx);
    tmtw_pkg::in_word_t w;
    w.opcode     = op;
    w.character  = ch;
    w.cell_index = idx;
    return w;
  endfunction

  function automatic tmtw_pkg::out_word_t make_result(int r, int c, int p, logic [15:0] v);
    tmtw_pkg::out_word_t o;
    o.cursor_row      = r[4:0];
    o.cursor_column   = c[6:0];
    o.cursor_position = p[10:0];
    o.cell_value      = v;
    return o;
  endfunction

  // Offers one word and holds it until taken; the sender pauses between most bursts.
  task automatic offer_word(input tmtw_pkg::in_word_t w, input bit typed,
                            input tmtw_pkg::out_word_t typed_result);
    tmtw_pkg::out_word_t predicted;
    int gap;
    if (!in_valid) in_valid <= 1'b1;
    in_word <= w;
    do @(posedge clk); while (!in_ready);
    step_console(w, predicted);
    pending_results.push_back(typed ? typed_result : predicted);
    words_accepted++;
    burst_left--;
    if (burst_left <= 0) begin
      burst_left = $urandom_range(1, 16);
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
      if (gap != 0) begin
        in_valid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
    end
  endtask

  task automatic write_attribute(input logic [7:0] a);
    if (in_valid) in_valid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
    repeat (8) @(posedge clk);
    cfg_valid <= 1'b1;
    cfg_data  <= a;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    shadow_attr = a;
    attr_writes++;
  endtask

  // Receiver: segments with their own stall rate, and a long hold-off on request.
  initial begin : receiver
    int stall_pct;
    int seg_left;
    stall_pct = 0;
    seg_left  = 0;
    forever begin
      @(posedge clk);
      if (hold_offs_done < hold_offs_wanted) begin
        out_ready <= 1'b0;
        repeat (HOLD_OFF_CYCLES) @(posedge clk);
        hold_offs_done++;
      end else begin
        if (seg_left == 0) begin
          seg_left = $urandom_range(8, 48);
          case ($urandom_range(0, 3))
            0: stall_pct = 0;
            1: stall_pct = 20;
            2: stall_pct = 50;
            default: stall_pct = 85;
          endcase
        end
        seg_left--;
        out_ready <= ($urandom_range(0, 99) >= stall_pct);
      end
    end
  end

  always @(posedge clk) begin : check_results
    tmtw_pkg::out_word_t want;
    if (rst_n && out_valid && out_ready) begin
      if (pending_results.size() == 0) begin
        error_count++;
        if (error_count <= 10)
          $display("unexpected word at %0t: row %0d col %0d pos %0d cell %h", $time,
                   out_word.cursor_row, out_word.cursor_column, out_word.cursor_position,
                   out_word.cell_value);
      end else begin
        want = pending_results.pop_front();
        results_checked++;
        if (out_word.cursor_row !== want.cursor_row ||
            out_word.cursor_column !== want.cursor_column ||
            out_word.cursor_position !== want.cursor_position ||
            out_word.cell_value !== want.cell_value) begin
          error_count++;
          if (error_count <= 10)
            $display({"mismatch at %0t: expected row %0d col %0d pos %0d cell %h, ",
                      "got row %0d col %0d pos %0d cell %h"},
                     $time, want.cursor_row, want.cursor_column, want.cursor_position,
                     want.cell_value, out_word.cursor_row, out_word.cursor_column,
                     out_word.cursor_position, out_word.cell_value);
        end
      end
    end
  end

  initial begin : stimulus
    stim_row_t          directed [$];
    tmtw_pkg::in_word_t w;
    logic [7:0]         ch;
    logic [7:0]         attr;
    int                 quota;
    int                 pick;
    int                 len;
    int                 near;

    for (int i = 0; i < CELLS; i++)
      shadow_cells[i] = {tmtw_pkg::RESET_ATTRIBUTE, tmtw_pkg::SPACE_BYTE};
    shadow_row  = 0;
    shadow_col  = 0;
    shadow_attr = tmtw_pkg::RESET_ATTRIBUTE;

    // Reset store, reads past the end, backspace at column zero.
    directed.push_back('{ROW_WORD, make_word(tmtw_pkg::OP_READ, 8'h00, 11'd0), 8'h00, 1'b1,
                         make_result(0, 0, 0, 16'h0720)});
    directed.push_back('{ROW_WORD, make_word(tmtw_pkg::OP_READ, 8'h00, 11'd1999), 8'h00, 1'b1,
                         make_result(0, 0, 0, 16'h0720)});
    directed.push_back('{ROW_WORD, make_word(tmtw_pkg::OP_READ, 8'h00, 11'd2047), 8'h00, 1'b1,
                         make_result(0, 0, 0, 16'h0000)});
    directed.push_back('{ROW_WORD, make_word(tmtw_pkg::OP_READ, 8'h00, 11'd2000), 8'h00, 1'b1,
                         make_result(0, 0, 0, 16'h0000)});
    directed.push_back('{ROW_WORD, make_word(tmtw_pkg::OP_BACKSPACE, 8'h00, 11'd0), 8'h00,
                         1'b1, make_result(0, 0, 0, 16'h0000)});
    // Attribute zero, high and low character bytes, backspace blanking.
    directed.push_back('{ROW_ATTR, '0, 8'h00, 1'b0, '0});
    directed.push_back('{ROW_WORD, make_word(tmtw_pkg::OP_WRITE, 8'h41, 11'd0), 8'h00, 1'b1,
                         make_result(0, 1, 1, 16'h0000)});
    directed.push_back('{ROW_WORD, make_word(tmtw_pkg::OP_WRITE, 8'hFF, 11'd0), 8'h00, 1'b1,
                         make_result(0, 2, 2, 16'h0000)});
    directed.push_back('{ROW_WORD, make_word(tmtw_pkg::OP_WRITE, 8'h00, 11'd0), 8'h00, 1'b1,
                         make_result(0, 3, 3, 16'h0000)});
    directed.push_back('{ROW_WORD, make_word(tmtw_pkg::OP_READ, 8'h00, 11'd1), 8'h00, 1'b1,
                         make_result(0, 3, 3, 16'h00FF)});
    directed.push_back('{ROW_WORD, make_word(tmtw_pkg::OP_READ, 8'h00, 11'd2), 8'h00, 1'b1,
                         make_result(0, 3, 3, 16'h0000)});
    directed.push_back('{ROW_WORD, make_word(tmtw_pkg::OP_BACKSPACE, 8'h00, 11'd0), 8'h00,
                         1'b1, make_result(0, 2, 2, 16'h0000)});
    directed.push_back('{ROW_WORD, make_word(tmtw_pkg::OP_READ, 8'h00, 11'd2), 8'h00, 1'b1,
                         make_result(0, 2, 2, 16'h0020)});
    // Attribute all ones, newline, clear leaving the cursor in place.
    directed.push_back('{ROW_ATTR, '0, 8'hFF, 1'b0, '0});
    directed.push_back('{ROW_WORD,
                         make_word(tmtw_pkg::OP_WRITE, tmtw_pkg::NEWLINE_BYTE, 11'd0),
                         8'h00, 1'b1, make_result(1, 0, 80, 16'h0000)});
    directed.push_back('{ROW_WORD, make_word(tmtw_pkg::OP_BACKSPACE, 8'h00, 11'd0), 8'h00,
                         1'b1, make_result(1, 0, 80, 16'h0000)});
    directed.push_back('{ROW_WORD, make_word(tmtw_pkg::OP_CLEAR, 8'h00, 11'd0), 8'h00, 1'b1,
                         make_result(1, 0, 80, 16'h0000)});
    directed.push_back('{ROW_WORD, make_word(tmtw_pkg::OP_READ, 8'h00, 11'd0), 8'h00, 1'b1,
                         make_result(1, 0, 80, 16'hFF20)});
    directed.push_back('{ROW_WORD, make_word(tmtw_pkg::OP_WRITE, 8'h80, 11'd0), 8'h00, 1'b1,
                         make_result(1, 1, 81, 16'h0000)});
    directed.push_back('{ROW_WORD, make_word(tmtw_pkg::OP_READ, 8'h00, 11'd80), 8'h00, 1'b1,
                         make_result(1, 1, 81, 16'hFF80)});
    directed.push_back('{ROW_ATTR, '0, 8'h5A, 1'b0, '0});
    directed.push_back('{ROW_WORD, make_word(tmtw_pkg::OP_WRITE, 8'h7F, 11'h7FF), 8'h00, 1'b0,
                         '0});
    directed.push_back('{ROW_WORD, make_word(tmtw_pkg::OP_READ, 8'hFF, 11'd1024), 8'h00, 1'b0,
                         '0});
    directed.push_back('{ROW_WORD, make_word(tmtw_pkg::OP_READ, 8'hFF, 11'd81), 8'h00, 1'b0,
                         '0});

    repeat (5) @(posedge clk);
    rst_n <= 1'b1;

    foreach (directed[i]) begin
      if (directed[i].kind == ROW_ATTR)
        write_attribute(directed[i].attr);
      else
        offer_word(directed[i].word, directed[i].typed, directed[i].result);
    end

    // Random part: mostly runs of text, line feeds, backspaces and reads near the cursor.
    for (int phase = 0; phase < 4; phase++) begin
      case (phase)
        1: attr = 8'h00;
        2: attr = 8'hFF;
        default: attr = 8'($urandom_range(0, 255));
      endcase
      write_attribute(attr);
      if (phase == 1 || phase == 3) hold_offs_wanted++;
      quota = words_accepted + PHASE_WORDS;
      while (words_accepted < quota) begin
        pick = $urandom_range(0, 99);
        if (pick < 35) begin
          len = ($urandom_range(0, 3) == 0) ? $urandom_range(60, 100) : $urandom_range(1, 30);
          repeat (len) begin
            ch = ($urandom_range(0, 3) == 0) ? 8'($urandom_range(0, 255))
                                             : 8'($urandom_range(32, 126));
            if (ch == tmtw_pkg::NEWLINE_BYTE) ch = tmtw_pkg::SPACE_BYTE;
            offer_word(make_word(tmtw_pkg::OP_WRITE, ch, 11'($urandom_range(0, 2047))),
                       1'b0, '0);
          end
          if ($urandom_range(0, 1) == 1)
            offer_word(make_word(tmtw_pkg::OP_WRITE, tmtw_pkg::NEWLINE_BYTE, 11'd0), 1'b0, '0);
        end else if (pick < 60) begin
          repeat ($urandom_range(1, 12))
            offer_word(make_word(tmtw_pkg::OP_WRITE, tmtw_pkg::NEWLINE_BYTE,
                                 11'($urandom_range(0, 2047))), 1'b0, '0);
        end else if (pick < 70) begin
          repeat ($urandom_range(1, 10))
            offer_word(make_word(tmtw_pkg::OP_BACKSPACE, 8'($urandom_range(0, 255)), 11'd0),
                       1'b0, '0);
        end else if (pick < 88) begin
          repeat ($urandom_range(1, 6)) begin
            case ($urandom_range(0, 9))
              0, 1, 2, 3, 4: begin
                near = int'(shadow_row * COLS + shadow_col) - int'($urandom_range(0, 12));
                if (near < 0) near = 0;
              end
              5, 6, 7: near = $urandom_range(0, CELLS - 1);
              default: near = $urandom_range(0, 2047);
            endcase
            offer_word(make_word(tmtw_pkg::OP_READ, 8'($urandom_range(0, 255)), 11'(near)),
                       1'b0, '0);
          end
        end else if (pick < 91) begin
          offer_word(make_word(tmtw_pkg::OP_CLEAR, 8'($urandom_range(0, 255)),
                               11'($urandom_range(0, 2047))), 1'b0, '0);
        end else begin
          w.opcode     = tmtw_pkg::opcode_t'($urandom_range(0, 3));
          w.character  = 8'($urandom_range(0, 255));
          w.cell_index = 11'($urandom_range(0, 2047));
          offer_word(w, 1'b0, '0);
        end
      end
    end

    if (in_valid) in_valid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
    repeat (20) @(posedge clk);

    $display("Sent %0d console words under %0d attribute settings: %0d scrolls, %0d clears, %0d reads.",
             words_accepted, attr_writes, scroll_count, clear_count, read_count);
    $display("Checked %0d results, %0d errors, %0d long receiver hold-offs.",
             results_checked, error_count, hold_offs_done);
    if (error_count == 0)
      $display("SUCCESS");
    else
      $display("FAILURE");
    $finish;
  end

endmodule

/* sim.f */
rtl/tmtw_pkg.sv
rtl/tmtw_datapath.sv
rtl/tmtw_ctrl.sv
rtl/text_mode_terminal_writer.sv
tb/testbench.sv
